// ----- sv/bdq_pkg.sv -----
package bdq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_SEARCH     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK
  } op_t;

  typedef struct packed {
    op_t   op;
    word_t key;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic tail;
  } cell_st_t;

endpackage

// ----- sv/bdq_if.sv -----
interface bdq_in_if;
  import bdq_pkg::*;

  logic          valid;
  logic          ready;
  logic [2:0]    kind;
  word_t         word_in;

  modport source (output valid, kind, word_in, input ready);
  modport sink   (input valid, kind, word_in, output ready);
endinterface

interface bdq_out_if;
  import bdq_pkg::*;

  logic          valid;
  logic          ready;
  word_t         word_out;
  logic          found;
  logic [1:0]    status;
  cnt_t          occupancy;

  modport source (output valid, word_out, found, status, occupancy, input ready);
  modport sink   (input valid, word_out, found, status, occupancy, output ready);
endinterface

// ----- sv/bdq_cell.sv -----
module bdq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  bdq_pkg::cmd_t     cmd,
  input  bdq_pkg::word_t    lo_word,
  input  logic              lo_occ,
  input  bdq_pkg::word_t    hi_word,
  input  logic              hi_occ,
  output bdq_pkg::word_t    word,
  output logic              occ,
  output bdq_pkg::cell_st_t st
);
  import bdq_pkg::*;

  word_t word_r, word_nxt;
  logic  occ_r, occ_nxt;

  always_comb begin
    word_nxt = word_r;
    occ_nxt  = occ_r;
    case (cmd.op)
      OP_PUSH_FRONT: begin
        word_nxt = lo_word;
        occ_nxt  = lo_occ;
      end
      OP_PUSH_BACK: begin
        if (!occ_r && lo_occ) begin
          word_nxt = cmd.key;
          occ_nxt  = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        word_nxt = hi_word;
        occ_nxt  = hi_occ;
      end
      OP_POP_BACK: begin
        if (occ_r && !hi_occ) begin
          occ_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign word     = word_r;
  assign occ      = occ_r;
  assign st.match = occ_r && (word_r == cmd.key);
  assign st.tail  = occ_r && !hi_occ;

endmodule

// ----- sv/bounded_deque_with_search.sv -----
// bounded double-ended queue of words with a membership search
// in_ch carries one request per transaction: kind (push front, push back,
// pop front, pop back, search) and word_in, the word to push or look for
// out_ch returns exactly one result per request: word_out (popped word),
// found (search hit), status (done, push refused because full, pop on
// empty) and occupancy (words held after the request)
// each result is registered and appears on out_ch in the cycle after its
// request is accepted
// throughput: one request per cycle while out_ch is not stalled; the words
// sit in a row of cells that shift together on front pushes and front pops,
// and every cell compares its word with the key in parallel for a search
// in_ch.ready stays high while the result register is empty or being taken;
// when the receiver stalls the result is held and in_ch.ready drops until
// out_ch.ready returns
// reset (rst_n low at a clock edge) empties the queue and drops out_ch.valid;
// the word storage itself is not cleared
module bounded_deque_with_search (
  input logic      clk,
  input logic      rst_n,
  bdq_in_if.sink   in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  cnt_t     count_r, count_nxt;
  logic     out_valid_r, out_valid_nxt;
  word_t    word_out_r, word_out_nxt;
  logic     found_r, found_nxt;
  status_t  status_r, status_nxt;
  cnt_t     occ_out_r;

  cmd_t     cmd;
  word_t    cell_word [DEPTH];
  logic     [DEPTH-1:0] occ_vec;
  cell_st_t cell_st [DEPTH];

  logic     fire;
  logic     full;
  logic     empty;
  logic     hit;
  word_t    tail_word;

  assign fire  = in_ch.valid && in_ch.ready;
  assign full  = (count_r == cnt_t'(DEPTH));
  assign empty = (count_r == '0);

  assign in_ch.ready = !out_valid_r || out_ch.ready;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      word_t lo_word, hi_word;
      logic  lo_occ, hi_occ;
      if (gi == 0) begin : g_head
        assign lo_word = in_ch.word_in;
        assign lo_occ  = 1'b1;
      end else begin : g_mid_lo
        assign lo_word = cell_word[gi-1];
        assign lo_occ  = occ_vec[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign hi_word = '0;
        assign hi_occ  = 1'b0;
      end else begin : g_mid_hi
        assign hi_word = cell_word[gi+1];
        assign hi_occ  = occ_vec[gi+1];
      end
      bdq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .lo_word (lo_word),
        .lo_occ  (lo_occ),
        .hi_word (hi_word),
        .hi_occ  (hi_occ),
        .word    (cell_word[gi]),
        .occ     (occ_vec[gi]),
        .st      (cell_st[gi])
      );
    end
  endgenerate

  always_comb begin
    hit       = 1'b0;
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit       = hit | cell_st[i].match;
      tail_word = tail_word | (cell_st[i].tail ? cell_word[i] : '0);
    end
  end

  always_comb begin
    cmd.op        = OP_IDLE;
    cmd.key       = in_ch.word_in;
    count_nxt     = count_r;
    word_out_nxt  = word_out_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      word_out_nxt  = '0;
      found_nxt     = 1'b0;
      status_nxt    = ST_DONE;
      case (in_ch.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.op    = (in_ch.kind == KIND_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            count_nxt = cnt_t'(count_r + 1'b1);
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.op       = OP_POP_FRONT;
            word_out_nxt = cell_word[0];
            count_nxt    = cnt_t'(count_r - 1'b1);
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.op       = OP_POP_BACK;
            word_out_nxt = tail_word;
            count_nxt    = cnt_t'(count_r - 1'b1);
          end
        end
        KIND_SEARCH: begin
          found_nxt = hit;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_out_r <= word_out_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    if (fire) begin
      occ_out_r <= count_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.word_out  = word_out_r;
  assign out_ch.found     = found_r;
  assign out_ch.status    = status_r;
  assign out_ch.occupancy = occ_out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("held count above depth");

  a_occ_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    occ_vec == ~({DEPTH{1'b1}} << count_r))
    else $error("cell occupancy does not match held count");

  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    fire && full && (in_ch.kind == KIND_PUSH_FRONT || in_ch.kind == KIND_PUSH_BACK)
    |=> status_r == ST_FULL && $stable(count_r) && $stable(occ_vec))
    else $error("push on full queue changed state");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    fire && empty && (in_ch.kind == KIND_POP_FRONT || in_ch.kind == KIND_POP_BACK)
    |=> status_r == ST_EMPTY && word_out_r == '0 && count_r == '0)
    else $error("pop on empty queue misreported");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !full && (in_ch.kind == KIND_PUSH_FRONT || in_ch.kind == KIND_PUSH_BACK)
    |=> count_r == cnt_t'($past(count_r) + 1'b1) && occ_out_r == count_r)
    else $error("push did not grow the queue by one");
`endif

endmodule
